[hw/rtl/assert_macros.svh]
// Assertion macros shared by the money_text_to_cents RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mtc_pkg.sv]
// Types, character codes and the power-of-ten scaling for money_text_to_cents.
// No dependencies.
package mtc_pkg;

    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_DOT   = 2'd1,
        MARK_COMMA = 2'd2
    } mark_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LC_C  = 8'h63;
    localparam logic [7:0] CHAR_UC_C  = 8'h43;

    // Finished value and how many fraction digits it still lacks.
    typedef struct packed {
        logic [63:0] acc;
        logic [1:0]  missing;
    } mtc_pend_t;

    // x * 10^k by shifts, adds and subtracts, wrapping modulo 2^64.
    function automatic logic [63:0] scale_pow10(input logic [63:0] x, input logic [1:0] k);
        logic [63:0] r;
        case (k)
            2'd0:    r = x;
            2'd1:    r = (x << 3) + (x << 1);
            2'd2:    r = (x << 6) + (x << 5) + (x << 2);
            default: r = (x << 10) - (x << 4) - (x << 3);
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mtc_parse.sv]
// Per-character parser state: accumulator, separator marks, fraction count.
// Depends on mtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtc_parse
    import mtc_pkg::*;
#(
    parameter int FRACTION_DIGITS = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      char_code,
    input  logic            last_char,
    output mtc_pend_t       pend
);

    localparam logic [1:0] FD_MAX = 2'(FRACTION_DIGITS);

    logic [63:0] acc_reg, acc_next;
    logic [1:0]  fd_reg, fd_next;
    mark_t       dec_reg, dec_next;
    mark_t       thou_reg, thou_next;
    logic        stopped_reg, stopped_next;
    logic        is_digit;
    logic [3:0]  digit;
    mark_t       code;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit    = 4'(char_code - CHAR_ZERO);
    assign code     = (char_code == CHAR_DOT) ? MARK_DOT : MARK_COMMA;

    always_comb
    begin
        acc_next     = acc_reg;
        fd_next      = fd_reg;
        dec_next     = dec_reg;
        thou_next    = thou_reg;
        stopped_next = stopped_reg;
        if (!stopped_reg)
        begin
            if (is_digit)
            begin
                acc_next = (acc_reg << 3) + (acc_reg << 1) + {60'd0, digit};
                if (dec_reg != MARK_NONE)
                begin
                    if (fd_reg >= FD_MAX)
                    begin
                        thou_next = dec_reg;
                        dec_next  = MARK_NONE;
                        fd_next   = 2'd0;
                    end
                    else
                    begin
                        fd_next = fd_reg + 2'd1;
                    end
                end
            end
            else if (char_code == CHAR_DOT || char_code == CHAR_COMMA)
            begin
                if (dec_reg != MARK_NONE)
                begin
                    thou_next = dec_reg;
                    dec_next  = MARK_NONE;
                    fd_next   = 2'd0;
                end
                else if (thou_reg != code)
                begin
                    dec_next = code;
                end
            end
            else if (char_code == CHAR_SPACE || char_code == CHAR_TAB)
            begin
                acc_next = acc_reg;
            end
            else if (char_code == CHAR_MINUS)
            begin
                acc_next = 64'd0 - acc_reg;
            end
            else if (char_code == CHAR_LC_C || char_code == CHAR_UC_C)
            begin
                acc_next     = 64'd0 - acc_reg;
                stopped_next = 1'b1;
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
    end

    assign pend.acc     = acc_next;
    assign pend.missing = FD_MAX - fd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            fd_reg      <= '0;
            dec_reg     <= MARK_NONE;
            thou_reg    <= MARK_NONE;
            stopped_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last_char)
            begin
                acc_reg     <= '0;
                fd_reg      <= '0;
                dec_reg     <= MARK_NONE;
                thou_reg    <= MARK_NONE;
                stopped_reg <= 1'b0;
            end
            else
            begin
                acc_reg     <= acc_next;
                fd_reg      <= fd_next;
                dec_reg     <= dec_next;
                thou_reg    <= thou_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    `MTC_ASSERT_NXT(a_clear_after_last, clk, rst_n, take && last_char,
        acc_reg == 64'd0 && !stopped_reg && fd_reg == 2'd0, "state not cleared after last")
    `MTC_ASSERT_NXT(a_stopped_holds, clk, rst_n, take && !last_char && stopped_reg,
        stopped_reg && $stable(acc_reg), "stopped parser changed its value")
    `MTC_ASSERT_IMP(a_fd_bound, clk, rst_n, 1'b1, fd_reg <= FD_MAX,
        "fraction count beyond limit")

endmodule

[hw/rtl/mtc_scale.sv]
// Holds a finished value, scales it to the fixed fraction width, drives the result.
// Depends on mtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtc_scale
    import mtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mtc_pend_t   pend,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] amount
);

    logic        pend_valid_reg;
    mtc_pend_t   pend_reg;
    logic        out_valid_reg;
    logic [63:0] amount_reg;
    logic        adv;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = !pend_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                pend_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pend_reg <= pend;
        end
        if (adv && pend_valid_reg)
        begin
            amount_reg <= scale_pow10(pend_reg.acc, pend_reg.missing);
        end
    end

    assign out_valid = out_valid_reg;
    assign amount    = amount_reg;

    `MTC_ASSERT_NXT(a_pend_loaded, clk, rst_n, in_valid && in_ready, pend_valid_reg,
        "accepted last transfer not held")
    `MTC_ASSERT_NXT(a_pend_moves, clk, rst_n, pend_valid_reg && adv, out_valid_reg,
        "held value did not reach output")

endmodule

[hw/rtl/money_text_to_cents.sv]
// money_text_to_cents: amount text, one byte per transfer, to signed hundredths.
// Throughput one byte per cycle while s_tready is high; the parser state updates
// at each input transfer. The result for the transfer carrying tlast passes a hold
// register, then the scaling multiply register, to m_tdata. Depends on mtc_pkg.
// rst_n (async, active low) clears the parser state and both valid flags.
// A stalled output holds the pipeline; s_tready drops only when both stages are full.
module money_text_to_cents
    import mtc_pkg::*;
#(
    parameter int FRACTION_DIGITS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] amount
);

    logic      take;
    mtc_pend_t pend;

    assign take = s_tvalid && s_tready;

    mtc_parse #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .pend      (pend)
    );

    mtc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take && s_tlast),
        .in_ready  (s_tready),
        .pend      (pend),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .amount    (m_tdata)
    );

endmodule
